// ===== rtl/core/mric_pkg.sv =====
// Shared types and constants for the linear index / coordinate converter.
`default_nettype none
package mric_pkg;

  localparam int unsigned FieldDims    = 4;
  localparam int unsigned IdxW         = 32;
  localparam int unsigned CrdW         = 8;
  localparam int unsigned StepBits     = 4;
  localparam int unsigned StagesPerDiv = IdxW / StepBits;
  localparam int unsigned DivGroups    = FieldDims - 1;
  // entry register + division stages + output register
  localparam int unsigned Latency      = 2 + DivGroups * StagesPerDiv;
  localparam int unsigned AddrW        = 5;

  localparam logic [2:0] RegNumDims  = 3'd0;
  localparam logic [2:0] RegDimSize0 = 3'd1;
  localparam logic [2:0] RegDimSize1 = 3'd2;
  localparam logic [2:0] RegDimSize2 = 3'd3;
  localparam logic [2:0] RegDimSize3 = 3'd4;

  localparam logic ReqIdxToCrd = 1'b0;
  localparam logic ReqCrdToIdx = 1'b1;

  typedef logic [FieldDims-1:0][CrdW-1:0] crd_vec_t;

  typedef struct packed {
    logic            valid;
    logic            req_type;
    logic            err;
    logic [IdxW-1:0] t;
    logic [CrdW-1:0] r;
    crd_vec_t        coord;
    logic [IdxW-1:0] idx;
  } pipe_t;

endpackage
`default_nettype wire

// ===== rtl/core/mric_front.sv =====
// Entry stage: register the transaction, gate unused coordinates, check ranges.
`default_nettype none
module mric_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic                          req_type_i,
  input  wire logic [mric_pkg::IdxW-1:0]     in_index_i,
  input  wire mric_pkg::crd_vec_t            in_coord_i,
  input  wire mric_pkg::crd_vec_t            size_i,
  input  wire logic [mric_pkg::FieldDims-1:0] used_i,
  output mric_pkg::pipe_t                    pipe_o
);

  mric_pkg::pipe_t pipe_d, pipe_q;

  always_comb begin
    logic err;
    err = 1'b0;
    pipe_d = '0;
    pipe_d.valid = accept_i;
    pipe_d.req_type = req_type_i;
    for (int k = 0; k < int'(mric_pkg::FieldDims); k++) begin
      if (used_i[k]) begin
        if (size_i[k] == '0) err = 1'b1;
        if (req_type_i == mric_pkg::ReqCrdToIdx) begin
          if (in_coord_i[k] >= size_i[k]) err = 1'b1;
          pipe_d.coord[k] = in_coord_i[k];
        end
      end
    end
    pipe_d.err = err;
    if (req_type_i == mric_pkg::ReqIdxToCrd) begin
      pipe_d.t = in_index_i;
    end else begin
      pipe_d.idx = {{(mric_pkg::IdxW-mric_pkg::CrdW){1'b0}}, in_coord_i[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule
`default_nettype wire

// ===== rtl/core/mric_div_stage.sv =====
// One pipeline stage: a few restoring-division steps, optionally one multiply-accumulate.
`default_nettype none
module mric_div_stage #(
  parameter int unsigned DIV_DIM = 3,
  parameter bit          LAST    = 1'b0,
  parameter bit          MAC     = 1'b0,
  parameter int unsigned MAC_DIM = 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [mric_pkg::CrdW-1:0] div_size_i,
  input  wire logic [mric_pkg::CrdW-1:0] mac_size_i,
  input  wire mric_pkg::pipe_t           pipe_i,
  output mric_pkg::pipe_t                pipe_o
);

  mric_pkg::pipe_t pipe_d, pipe_q;

  always_comb begin
    logic [mric_pkg::CrdW:0]   rr;
    logic [mric_pkg::CrdW-1:0] r;
    logic [mric_pkg::IdxW-1:0] t;
    logic [mric_pkg::IdxW+mric_pkg::CrdW-1:0] prod;
    pipe_d = pipe_i;
    r = pipe_i.r;
    t = pipe_i.t;
    prod = '0;
    for (int s = 0; s < int'(mric_pkg::StepBits); s++) begin
      rr = {r, t[mric_pkg::IdxW-1]};
      t = {t[mric_pkg::IdxW-2:0], 1'b0};
      if (rr >= {1'b0, div_size_i}) begin
        rr = rr - {1'b0, div_size_i};
        t[0] = 1'b1;
      end
      r = rr[mric_pkg::CrdW-1:0];
    end
    pipe_d.t = t;
    pipe_d.r = r;
    if (LAST) begin
      // remainder is this dimension's coordinate; restart for the next divisor
      pipe_d.r = '0;
      if (pipe_i.req_type == mric_pkg::ReqIdxToCrd) pipe_d.coord[DIV_DIM] = r;
    end
    if (MAC) begin
      prod = pipe_i.idx * mac_size_i;
      pipe_d.idx = prod[mric_pkg::IdxW-1:0]
                 + {{(mric_pkg::IdxW-mric_pkg::CrdW){1'b0}}, pipe_i.coord[MAC_DIM]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule
`default_nettype wire

// ===== rtl/core/mixed_radix_index_convert_unit.sv =====
// An accepted start passes the entry register, the division stages and the output register to done_o.
// Throughput: one transaction per cycle; busy stays low, results never stall.
// Each divisor takes eight 4-bit restoring stages; the three divisions run in series.
// Reset clears the pipeline valid bits and the registers to num_dims 2, sizes 1.
// Top level: configuration port, clamp of dimension count, pipeline and output register.
`default_nettype none
module mixed_radix_index_convert_unit #(
  parameter int unsigned MAX_DIMS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mric_pkg::AddrW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type_i,
  input  wire logic [31:0]                   in_index_i,
  input  wire logic [7:0]                    in_coord_0_i,
  input  wire logic [7:0]                    in_coord_1_i,
  input  wire logic [7:0]                    in_coord_2_i,
  input  wire logic [7:0]                    in_coord_3_i,
  output logic                               done_o,
  output logic [31:0]                        out_index_o,
  output logic [7:0]                         out_coord_0_o,
  output logic [7:0]                         out_coord_1_o,
  output logic [7:0]                         out_coord_2_o,
  output logic [7:0]                         out_coord_3_o,
  output logic                               range_error_o
);

  localparam int unsigned DimLimit = (MAX_DIMS < mric_pkg::FieldDims) ? MAX_DIMS
                                                                      : mric_pkg::FieldDims;
  localparam int unsigned Groups = mric_pkg::DivGroups;
  localparam int unsigned Spd    = mric_pkg::StagesPerDiv;

  logic [2:0]         num_dims_q;
  mric_pkg::crd_vec_t size_q;
  logic               wr_en;
  logic [2:0]         reg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = paddr[mric_pkg::AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= 3'd2;
      size_q     <= {mric_pkg::FieldDims{8'd1}};
    end else if (wr_en) begin
      case (reg_sel)
        mric_pkg::RegNumDims:  num_dims_q <= pwdata[2:0];
        mric_pkg::RegDimSize0: size_q[0]  <= pwdata[7:0];
        mric_pkg::RegDimSize1: size_q[1]  <= pwdata[7:0];
        mric_pkg::RegDimSize2: size_q[2]  <= pwdata[7:0];
        mric_pkg::RegDimSize3: size_q[3]  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mric_pkg::RegNumDims:  prdata = {29'd0, num_dims_q};
      mric_pkg::RegDimSize0: prdata = {24'd0, size_q[0]};
      mric_pkg::RegDimSize1: prdata = {24'd0, size_q[1]};
      mric_pkg::RegDimSize2: prdata = {24'd0, size_q[2]};
      mric_pkg::RegDimSize3: prdata = {24'd0, size_q[3]};
      default:               prdata = '0;
    endcase
  end

  // clamp the dimension count, then give unused dimensions an effective size of one
  logic [2:0]                        n_used;
  logic [mric_pkg::FieldDims-1:0]    used;
  mric_pkg::crd_vec_t                size_eff;

  always_comb begin
    if (num_dims_q < 3'd2) begin
      n_used = 3'd2;
    end else if (num_dims_q > 3'(DimLimit)) begin
      n_used = 3'(DimLimit);
    end else begin
      n_used = num_dims_q;
    end
    for (int k = 0; k < int'(mric_pkg::FieldDims); k++) begin
      used[k]     = (k < int'(n_used));
      size_eff[k] = used[k] ? size_q[k] : 8'd1;
    end
  end

  mric_pkg::crd_vec_t in_coord;
  assign in_coord = {in_coord_3_i, in_coord_2_i, in_coord_1_i, in_coord_0_i};

  mric_pkg::pipe_t pipe [Groups*Spd+1];

  mric_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (start && !busy),
    .req_type_i (req_type_i),
    .in_index_i (in_index_i),
    .in_coord_i (in_coord),
    .size_i     (size_eff),
    .used_i     (used),
    .pipe_o     (pipe[0])
  );

  for (genvar g = 0; g < Groups; g++) begin : g_div
    for (genvar j = 0; j < Spd; j++) begin : g_step
      mric_div_stage #(
        .DIV_DIM (mric_pkg::FieldDims - 1 - g),
        .LAST    (j == Spd - 1),
        .MAC     (j == 0),
        .MAC_DIM (g + 1)
      ) u_stage (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .div_size_i (size_eff[mric_pkg::FieldDims-1-g]),
        .mac_size_i (size_eff[g+1]),
        .pipe_i     (pipe[g*Spd+j]),
        .pipe_o     (pipe[g*Spd+j+1])
      );
    end
  end

  mric_pkg::pipe_t    last;
  logic               done_q;
  logic [31:0]        index_d, index_q;
  mric_pkg::crd_vec_t coord_d, coord_q;
  logic               err_d, err_q;

  assign last = pipe[Groups*Spd];

  // final quotient is coordinate 0; it must lie below the first size
  always_comb begin
    err_d = last.err;
    if (last.req_type == mric_pkg::ReqIdxToCrd
        && last.t >= {24'd0, size_eff[0]}) err_d = 1'b1;
    index_d = '0;
    coord_d = '0;
    if (!err_d) begin
      if (last.req_type == mric_pkg::ReqCrdToIdx) begin
        index_d = last.idx;
      end else begin
        coord_d    = last.coord;
        coord_d[0] = last.t[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      err_q   <= 1'b0;
      index_q <= '0;
      coord_q <= '0;
    end else begin
      done_q  <= last.valid;
      err_q   <= err_d;
      index_q <= index_d;
      coord_q <= coord_d;
    end
  end

  assign done_o        = done_q;
  assign out_index_o   = index_q;
  assign out_coord_0_o = coord_q[0];
  assign out_coord_1_o = coord_q[1];
  assign out_coord_2_o = coord_q[2];
  assign out_coord_3_o = coord_q[3];
  assign range_error_o = err_q;

endmodule
`default_nettype wire

// ===== rtl/core/mric_checker.sv =====
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module mric_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        done_o,
  input wire logic [31:0] out_index_o,
  input wire logic [7:0]  out_coord_0_o,
  input wire logic [7:0]  out_coord_1_o,
  input wire logic [7:0]  out_coord_2_o,
  input wire logic [7:0]  out_coord_3_o,
  input wire logic        range_error_o
);

  logic crd_zero;
  assign crd_zero = out_coord_0_o == 8'd0 && out_coord_1_o == 8'd0
                 && out_coord_2_o == 8'd0 && out_coord_3_o == 8'd0;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && range_error_o |-> out_index_o == 32'd0 && crd_zero)
    else $error("error result carries nonzero fields");

  a_one_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_index_o != 32'd0 |-> crd_zero)
    else $error("index and coordinates both nonzero");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, mric_pkg::Latency))
    else $error("result without matching start");

endmodule

bind mixed_radix_index_convert_unit mric_checker u_mric_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .done_o        (done_o),
  .out_index_o   (out_index_o),
  .out_coord_0_o (out_coord_0_o),
  .out_coord_1_o (out_coord_1_o),
  .out_coord_2_o (out_coord_2_o),
  .out_coord_3_o (out_coord_3_o),
  .range_error_o (range_error_o)
);
`default_nettype wire
